/* rtl/core/fcpa_pkg.sv */
`timescale 1ns / 1ps

package fcpa_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_RESET = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // Response status codes
   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_SIZE       = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_NONE_USED  = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_FILL = 2'd2
   } state_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_CHUNK_SIZE   = 2'd1;
   localparam logic [1:0] CSR_CHUNK_COUNT  = 2'd2;

   localparam int unsigned CSR_WIDTH = 32;

   // Register reset values
   localparam logic [31:0] BASE_RESET  = 32'd0;
   localparam logic [16:0] SIZE_RESET  = 17'd8;
   localparam logic [10:0] COUNT_RESET = 11'd1024;

   typedef struct packed {
      kind_type    kind;
      logic [16:0] request_size;
      logic [31:0] release_address;
   } req_type;

   typedef struct packed {
      logic [31:0] chunk_address;
      status_type  status;
      logic [26:0] used_bytes;
      logic [26:0] peak_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base_address;
      logic [16:0] chunk_size;
      logic [10:0] chunk_count;
   } cfg_type;

endpackage

/* rtl/core/fcpa_stack_ram.sv */
`timescale 1ns / 1ps

// Free-list stack storage: one write port, one registered read port
module fcpa_stack_ram #(
   parameter int unsigned DEPTH      = 1024,
   parameter int unsigned IDX_WIDTH  = 10,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_WIDTH-1:0]  wr_idx,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [IDX_WIDTH-1:0]  rd_idx,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] stack_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fcpa_ctrl.sv */
`timescale 1ns / 1ps

// Allocator sequencer: request decode, counters, pool refill walk, response register
module fcpa_ctrl #(
   parameter int unsigned MAX_CHUNKS = 1024,
   parameter int unsigned ADDR_WIDTH = 32,
   parameter int unsigned IDX_WIDTH  = 10,
   parameter int unsigned CNT_WIDTH  = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fcpa_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fcpa_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fcpa_pkg::rsp_type       rsp_data,
   output logic                    mem_we,
   output logic [IDX_WIDTH-1:0]    mem_widx,
   output logic [ADDR_WIDTH-1:0]   mem_wdata,
   output logic                    mem_re,
   output logic [IDX_WIDTH-1:0]    mem_ridx,
   input  logic [ADDR_WIDTH-1:0]   mem_rdata
);

   localparam logic [CNT_WIDTH-1:0] COUNT_FULL = CNT_WIDTH'(MAX_CHUNKS);

   fcpa_pkg::state_type    state_ff, state_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [26:0]            used_ff, used_in;
   logic [26:0]            peak_ff, peak_in;
   logic [CNT_WIDTH-1:0]   fill_idx_ff, fill_idx_in;
   logic [CNT_WIDTH-1:0]   fill_n_ff, fill_n_in;
   logic [ADDR_WIDTH-1:0]  fill_addr_ff, fill_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fcpa_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [CNT_WIDTH-1:0]   count_dec;
   logic [27:0]            used_sum;
   logic [26:0]            used_sat;
   logic [26:0]            chunk_27;
   logic [63:0]            rel_wide;
   logic [63:0]            base_wide;
   logic [63:0]            chunk_wide;
   logic [63:0]            rd_wide;
   logic [31:0]            cc_wide;
   logic [CNT_WIDTH-1:0]   refill_n;

   // Operand shaping
   always_comb begin
      count_dec  = count_ff - CNT_WIDTH'(1);
      chunk_27   = {10'd0, cfg.chunk_size};
      used_sum   = {1'b0, used_ff} + {11'd0, cfg.chunk_size};
      used_sat   = used_sum[27] ? 27'h7FF_FFFF : used_sum[26:0];
      rel_wide   = {32'd0, req_data.release_address};
      base_wide  = {32'd0, cfg.base_address};
      chunk_wide = {47'd0, cfg.chunk_size};
      rd_wide    = 64'(mem_rdata);
      cc_wide    = {21'd0, cfg.chunk_count};
      refill_n   = (cc_wide > 32'(MAX_CHUNKS)) ? COUNT_FULL : cc_wide[CNT_WIDTH-1:0];
   end

   // State register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcpa_pkg::S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_idx_ff  <= fill_idx_in;
      fill_n_ff    <= fill_n_in;
      fill_addr_ff <= fill_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Next state, counters, memory access and response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      fill_idx_in  = fill_idx_ff;
      fill_n_in    = fill_n_ff;
      fill_addr_in = fill_addr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_widx     = count_ff[IDX_WIDTH-1:0];
      mem_wdata    = rel_wide[ADDR_WIDTH-1:0];
      mem_re       = 1'b0;
      mem_ridx     = count_dec[IDX_WIDTH-1:0];

      // new request only when idle and the response slot is free by this edge
      req_stall = !((state_ff == fcpa_pkg::S_IDLE) && (!rsp_valid_ff || !rsp_stall));
      accept    = req_valid && !req_stall;

      case (state_ff)
         fcpa_pkg::S_IDLE: begin
            if (accept) begin
               rsp_data_in.chunk_address = '0;
               rsp_data_in.status        = fcpa_pkg::STAT_OK;
               rsp_data_in.used_bytes    = used_ff;
               rsp_data_in.peak_bytes    = peak_ff;
               case (req_data.kind)
                  fcpa_pkg::KIND_ALLOC: begin
                     if (req_data.request_size != cfg.chunk_size) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = fcpa_pkg::STAT_SIZE;
                     end else if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = fcpa_pkg::STAT_EMPTY;
                     end else begin
                        // pop: address arrives from the RAM next cycle
                        mem_re   = 1'b1;
                        count_in = count_dec;
                        used_in  = used_sat;
                        peak_in  = (used_sat > peak_ff) ? used_sat : peak_ff;
                        state_in = fcpa_pkg::S_READ;
                     end
                  end
                  fcpa_pkg::KIND_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= COUNT_FULL) begin
                        rsp_data_in.status = fcpa_pkg::STAT_FULL;
                     end else if ((used_ff == '0) || (used_ff < chunk_27)) begin
                        rsp_data_in.status = fcpa_pkg::STAT_NONE_USED;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_WIDTH'(1);
                        used_in  = used_ff - chunk_27;
                        rsp_data_in.used_bytes = used_ff - chunk_27;
                     end
                  end
                  fcpa_pkg::KIND_RESET: begin
                     count_in     = '0;
                     used_in      = '0;
                     peak_in      = '0;
                     fill_idx_in  = '0;
                     fill_n_in    = refill_n;
                     fill_addr_in = base_wide[ADDR_WIDTH-1:0];
                     rsp_data_in.used_bytes = '0;
                     rsp_data_in.peak_bytes = '0;
                     if (refill_n == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = fcpa_pkg::S_FILL;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         fcpa_pkg::S_READ: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.chunk_address = rd_wide[31:0];
            rsp_data_in.status        = fcpa_pkg::STAT_OK;
            rsp_data_in.used_bytes    = used_ff;
            rsp_data_in.peak_bytes    = peak_ff;
            state_in                  = fcpa_pkg::S_IDLE;
         end

         fcpa_pkg::S_FILL: begin
            // one chunk address pushed per cycle, lowest first
            mem_we       = 1'b1;
            mem_widx     = fill_idx_ff[IDX_WIDTH-1:0];
            mem_wdata    = fill_addr_ff;
            fill_addr_in = fill_addr_ff + chunk_wide[ADDR_WIDTH-1:0];
            fill_idx_in  = fill_idx_ff + CNT_WIDTH'(1);
            if (fill_idx_ff == (fill_n_ff - CNT_WIDTH'(1))) begin
               count_in                  = fill_n_ff;
               rsp_valid_in              = 1'b1;
               rsp_data_in.chunk_address = '0;
               rsp_data_in.status        = fcpa_pkg::STAT_OK;
               rsp_data_in.used_bytes    = '0;
               rsp_data_in.peak_bytes    = '0;
               state_in                  = fcpa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fcpa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/fixed_chunk_pool_allocator.sv */
`timescale 1ns / 1ps

// Fixed-size chunk pool allocator with a LIFO free list held in a single RAM.
// Request channel (req_valid/req_stall/req_data): allocate, free, pool reset
// or no-op. Response channel (rsp_valid/rsp_stall/rsp_data): exactly one
// response per request, in order, from a response register.
// Path per request, from acceptance to response valid:
//   free, no-op, any refused request : response register only
//   allocate                         : RAM read register, then response register
//   pool reset                       : N chunk addresses written, N = min(chunk_count,
//                                      MAX_CHUNKS), one per cycle through the RAM
//                                      write port, then the response register
// A new request is taken in the cycle its predecessor's response is being
// taken, so unstalled frees run one per cycle; allocates wait out their RAM read.
// A stalled response holds in its register and blocks further requests.
// Reset: counters and stack depth clear, registers return to base 0, chunk
// size 8, chunk count 1024; the pool is empty until a pool reset request.
// CSR writes (csr_we/csr_addr/csr_wdata) belong to idle periods only.
module fixed_chunk_pool_allocator #(
   parameter int unsigned MAX_CHUNKS = 1024,
   parameter int unsigned ADDR_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fcpa_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fcpa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_addr,
   input  logic [fcpa_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int unsigned IDX_WIDTH = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(MAX_CHUNKS + 1);

   logic [31:0]            base_ff;
   logic [16:0]            size_ff;
   logic [10:0]            count_ff;
   fcpa_pkg::cfg_type      cfg;

   logic                   mem_we;
   logic [IDX_WIDTH-1:0]   mem_widx;
   logic [ADDR_WIDTH-1:0]  mem_wdata;
   logic                   mem_re;
   logic [IDX_WIDTH-1:0]   mem_ridx;
   logic [ADDR_WIDTH-1:0]  mem_rdata;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= fcpa_pkg::BASE_RESET;
         size_ff  <= fcpa_pkg::SIZE_RESET;
         count_ff <= fcpa_pkg::COUNT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            fcpa_pkg::CSR_BASE_ADDRESS: base_ff  <= csr_wdata;
            fcpa_pkg::CSR_CHUNK_SIZE:   size_ff  <= csr_wdata[16:0];
            fcpa_pkg::CSR_CHUNK_COUNT:  count_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign cfg.base_address = base_ff;
   assign cfg.chunk_size   = size_ff;
   assign cfg.chunk_count  = count_ff;

   fcpa_ctrl #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .ADDR_WIDTH (ADDR_WIDTH),
      .IDX_WIDTH  (IDX_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_widx  (mem_widx),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_ridx  (mem_ridx),
      .mem_rdata (mem_rdata)
   );

   fcpa_stack_ram #(
      .DEPTH      (MAX_CHUNKS),
      .IDX_WIDTH  (IDX_WIDTH),
      .DATA_WIDTH (ADDR_WIDTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_widx),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_idx  (mem_ridx),
      .rd_data (mem_rdata)
   );

endmodule

/* rtl/core/fcpa_checker.sv */
`timescale 1ns / 1ps

// Port-level checks on the allocator
module fcpa_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  fcpa_pkg::rsp_type rsp_data
);

   // no response is pending straight after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // peak never below current usage
   a_peak_ge_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.peak_bytes >= rsp_data.used_bytes))
      else $error("peak below used bytes");

   // refused requests hand out no address
   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != fcpa_pkg::STAT_OK))
         |-> (rsp_data.chunk_address == 32'd0))
      else $error("address returned with error status");

   // a pending stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response stalled");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
